// ===== hdl/its_pkg.sv =====
// Shared widths, status codes and transfer types of the intercept time solver.
package its_pkg;

    localparam int IN_WIDTH = 24;
    localparam int OUT_FRAC = 16;
    localparam int TIME_W   = 32;
    localparam int LIMIT_W  = 16;
    localparam int STAT_W   = 3;
    localparam int SUM_W    = 2 * IN_WIDTH;
    localparam int HALF_W   = IN_WIDTH;
    localparam int ROOT_W   = SUM_W + 1;
    localparam int DISC_W   = 2 * ROOT_W;
    localparam int NEG_W    = ROOT_W + 2;
    localparam int NUM_W    = ROOT_W + OUT_FRAC + 1;
    localparam int CMP_W    = SUM_W + TIME_W;

    localparam logic [STAT_W-1:0] ST_ROOT   = 3'd0;
    localparam logic [STAT_W-1:0] ST_STILL  = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOROOT = 3'd2;
    localparam logic [STAT_W-1:0] ST_LINEAR = 3'd3;
    localparam logic [STAT_W-1:0] ST_SAT    = 3'd4;

    typedef struct packed {
        logic        [IN_WIDTH-2:0] proj_speed;
        logic signed [IN_WIDTH-1:0] pos_x;
        logic signed [IN_WIDTH-1:0] pos_y;
        logic signed [IN_WIDTH-1:0] pos_z;
        logic signed [IN_WIDTH-1:0] vel_x;
        logic signed [IN_WIDTH-1:0] vel_y;
        logic signed [IN_WIDTH-1:0] vel_z;
    } t_in_item;

    typedef struct packed {
        logic [TIME_W-1:0] hit_time;
        logic [STAT_W-1:0] solve_status;
    } t_out_item;

    typedef struct packed {
        logic             still;
        logic             lin;
        logic             aneg;
        logic             dot_neg;
        logic             dneg;
        logic [SUM_W-1:0] absdot;
        logic [SUM_W-1:0] absa;
        logic [SUM_W-1:0] c;
    } t_ctx;

endpackage

// ===== hdl/its_coef.sv =====
// Coefficient stages: axis products, sums, quadratic term a and the near-zero flags.
module its_coef (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  its_pkg::t_in_item             i_data,
    input  logic [its_pkg::LIMIT_W-1:0]   i_limit,
    output logic                          o_valid,
    output its_pkg::t_ctx                 o_ctx
);
    import its_pkg::*;

    logic signed [IN_WIDTH-1:0] w_p [3];
    logic signed [IN_WIDTH-1:0] w_v [3];
    logic signed [SUM_W-1:0]    w_vv [3];
    logic signed [SUM_W-1:0]    w_pp [3];
    logic signed [SUM_W-1:0]    w_vp [3];
    logic [SUM_W-1:0]           w_ss;

    logic                       r_v1, r_v2, r_v3, r_v4;
    logic [SUM_W-1:0]           r1_vv [3];
    logic [SUM_W-1:0]           r1_pp [3];
    logic signed [SUM_W-1:0]    r1_vp [3];
    logic [SUM_W-1:0]           r1_ss;
    logic [SUM_W-1:0]           r2_velsq, r2_c, r2_ss;
    logic signed [SUM_W:0]      r2_dot;
    logic signed [SUM_W:0]      r3_a, r3_dot;
    logic [SUM_W-1:0]           r3_c;
    logic                       r3_still;
    t_ctx                       r4_ctx;
    logic [SUM_W-1:0]           w_absa, w_absdot;

    assign w_p[0] = i_data.pos_x;
    assign w_p[1] = i_data.pos_y;
    assign w_p[2] = i_data.pos_z;
    assign w_v[0] = i_data.vel_x;
    assign w_v[1] = i_data.vel_y;
    assign w_v[2] = i_data.vel_z;

    for (genvar k = 0; k < 3; k++) begin : g_axis
        assign w_vv[k] = w_v[k] * w_v[k];
        assign w_pp[k] = w_p[k] * w_p[k];
        assign w_vp[k] = w_v[k] * w_p[k];
    end

    assign w_ss     = i_data.proj_speed * i_data.proj_speed;
    assign w_absa   = r3_a[SUM_W] ? SUM_W'(-r3_a) : SUM_W'(r3_a);
    assign w_absdot = r3_dot[SUM_W] ? SUM_W'(-r3_dot) : SUM_W'(r3_dot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_vv[k] <= w_vv[k];
                r1_pp[k] <= w_pp[k];
                r1_vp[k] <= w_vp[k];
            end
            r1_ss <= w_ss;

            r2_velsq <= r1_vv[0] + r1_vv[1] + r1_vv[2];
            r2_c     <= r1_pp[0] + r1_pp[1] + r1_pp[2];
            r2_dot   <= (SUM_W+1)'(r1_vp[0]) + (SUM_W+1)'(r1_vp[1])
                        + (SUM_W+1)'(r1_vp[2]);
            r2_ss    <= r1_ss;

            r3_a     <= signed'({1'b0, r2_velsq}) - signed'({1'b0, r2_ss});
            r3_dot   <= r2_dot;
            r3_c     <= r2_c;
            r3_still <= r2_velsq < SUM_W'(i_limit);

            r4_ctx.still   <= r3_still;
            r4_ctx.lin     <= (w_absa == '0) || (w_absa < SUM_W'(i_limit));
            r4_ctx.aneg    <= r3_a[SUM_W];
            r4_ctx.dot_neg <= r3_dot[SUM_W];
            r4_ctx.dneg    <= 1'b0;
            r4_ctx.absdot  <= w_absdot;
            r4_ctx.absa    <= w_absa;
            r4_ctx.c       <= r3_c;
        end
    end

    assign o_valid = r_v4;
    assign o_ctx   = r4_ctx;

endmodule

// ===== hdl/its_disc.sv =====
// Discriminant stages: split products for the dot product squared and a times c, then their signed difference.
module its_disc (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  its_pkg::t_ctx                i_ctx,
    output logic                         o_valid,
    output its_pkg::t_ctx                o_ctx,
    output logic [its_pkg::DISC_W-1:0]   o_dmag
);
    import its_pkg::*;

    logic [HALF_W-1:0]   w_dl, w_dh, w_al, w_ah, w_cl, w_ch;
    logic                r_v5, r_v6, r_v7;
    t_ctx                r5_ctx, r6_ctx, r7_ctx;
    logic [SUM_W-1:0]    r5_dll, r5_dlh, r5_dhh;
    logic [SUM_W-1:0]    r5_all, r5_alh, r5_ahl, r5_ahh;
    logic [2*SUM_W-1:0]  r6_dsq, r6_ac;
    logic [DISC_W-1:0]   r7_dmag;
    logic [DISC_W:0]     w_dsq_x, w_ac_x, w_sum;
    t_ctx                w_ctx7;

    assign w_dl = i_ctx.absdot[HALF_W-1:0];
    assign w_dh = i_ctx.absdot[SUM_W-1:HALF_W];
    assign w_al = i_ctx.absa[HALF_W-1:0];
    assign w_ah = i_ctx.absa[SUM_W-1:HALF_W];
    assign w_cl = i_ctx.c[HALF_W-1:0];
    assign w_ch = i_ctx.c[SUM_W-1:HALF_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (i_en) begin
            r_v5 <= i_valid;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    assign w_dsq_x = (DISC_W+1)'(r6_dsq);
    assign w_ac_x  = (DISC_W+1)'(r6_ac);
    assign w_sum   = r6_ctx.aneg ? (w_dsq_x + w_ac_x) : (w_dsq_x - w_ac_x);

    always_comb begin
        w_ctx7      = r6_ctx;
        w_ctx7.dneg = w_sum[DISC_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_ctx <= i_ctx;
            r5_dll <= w_dl * w_dl;
            r5_dlh <= w_dl * w_dh;
            r5_dhh <= w_dh * w_dh;
            r5_all <= w_al * w_cl;
            r5_alh <= w_al * w_ch;
            r5_ahl <= w_ah * w_cl;
            r5_ahh <= w_ah * w_ch;

            r6_ctx <= r5_ctx;
            r6_dsq <= {r5_dhh, r5_dll} + ((2*SUM_W)'(r5_dlh) << (HALF_W + 1));
            r6_ac  <= {r5_ahh, r5_all} + ((2*SUM_W)'(r5_alh) << HALF_W)
                      + ((2*SUM_W)'(r5_ahl) << HALF_W);

            r7_ctx  <= w_ctx7;
            r7_dmag <= w_sum[DISC_W-1:0];
        end
    end

    assign o_valid = r_v7;
    assign o_ctx   = r7_ctx;
    assign o_dmag  = r7_dmag;

endmodule

// ===== hdl/its_sqrt.sv =====
// Pipelined floor square root of the discriminant, one root bit per stage.
module its_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  its_pkg::t_ctx                i_ctx,
    input  logic [its_pkg::DISC_W-1:0]   i_dmag,
    output logic                         o_valid,
    output its_pkg::t_ctx                o_ctx,
    output logic [its_pkg::ROOT_W-1:0]   o_root
);
    import its_pkg::*;

    logic                r_vld  [ROOT_W];
    t_ctx                r_ctx  [ROOT_W];
    logic [DISC_W-1:0]   r_x    [ROOT_W];
    logic [ROOT_W+1:0]   r_rem  [ROOT_W];
    logic [ROOT_W-1:0]   r_root [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic                w_v;
        t_ctx                w_ctx;
        logic [DISC_W-1:0]   w_x;
        logic [ROOT_W+1:0]   w_rem, w_sh, w_trial;
        logic [ROOT_W-1:0]   w_root;

        if (k == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_ctx  = i_ctx;
            assign w_x    = i_dmag;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_v    = r_vld[k-1];
            assign w_ctx  = r_ctx[k-1];
            assign w_x    = r_x[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
        end

        assign w_sh    = {w_rem[ROOT_W-1:0], w_x[DISC_W-1 -: 2]};
        assign w_trial = {w_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctx[k] <= w_ctx;
                r_x[k]   <= w_x << 2;
                if (w_sh >= w_trial) begin
                    r_rem[k]  <= w_sh - w_trial;
                    r_root[k] <= {w_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_sh;
                    r_root[k] <= {w_root[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_ctx   = r_ctx[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];

endmodule

// ===== hdl/its_div.sv =====
// Root selection, saturation check, pipelined restoring divider and result register.
module its_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  its_pkg::t_ctx                i_ctx,
    input  logic [its_pkg::ROOT_W-1:0]   i_root,
    output logic                         o_valid,
    output its_pkg::t_out_item           o_data
);
    import its_pkg::*;

    logic signed [NEG_W-1:0]  w_mdot, w_rt;
    logic                     r_va, r_vb, r_vc, r_vo;
    t_ctx                     ra_ctx;
    logic signed [NEG_W-1:0]  ra_n0, ra_n1;

    logic                     w_ok0, w_ok1;
    logic [NEG_W-2:0]         w_mag0, w_mag1, w_best;
    logic                     n_do;
    logic [NUM_W-1:0]         n_num;
    logic [SUM_W-1:0]         n_den;
    logic [STAT_W-1:0]        n_stat;

    logic                     rb_do;
    logic [NUM_W-1:0]         rb_num;
    logic [SUM_W-1:0]         rb_den;
    logic [STAT_W-1:0]        rb_stat;

    logic                     rc_do, rc_sat;
    logic [CMP_W-1:0]         rc_rem;
    logic [SUM_W-1:0]         rc_den;
    logic [STAT_W-1:0]        rc_stat;

    logic                     r_dv   [TIME_W];
    logic                     r_ddo  [TIME_W];
    logic                     r_dsat [TIME_W];
    logic [STAT_W-1:0]        r_dst  [TIME_W];
    logic [SUM_W-1:0]         r_dden [TIME_W];
    logic [CMP_W-1:0]         r_drem [TIME_W];
    logic [TIME_W-1:0]        r_dq   [TIME_W];

    t_out_item                r_out;

    assign w_rt   = signed'(NEG_W'(i_root));
    assign w_mdot = i_ctx.dot_neg ? signed'(NEG_W'(i_ctx.absdot))
                                  : -signed'(NEG_W'(i_ctx.absdot));

    assign w_ok0  = (ra_n0 != '0) && (ra_n0[NEG_W-1] == ra_ctx.aneg);
    assign w_ok1  = (ra_n1 != '0) && (ra_n1[NEG_W-1] == ra_ctx.aneg);
    assign w_mag0 = ra_n0[NEG_W-1] ? (NEG_W-1)'(-ra_n0) : (NEG_W-1)'(ra_n0);
    assign w_mag1 = ra_n1[NEG_W-1] ? (NEG_W-1)'(-ra_n1) : (NEG_W-1)'(ra_n1);
    assign w_best = (w_ok0 && (!w_ok1 || (w_mag0 < w_mag1))) ? w_mag0 : w_mag1;

    always_comb begin
        n_do   = 1'b0;
        n_num  = '0;
        n_den  = '0;
        n_stat = ST_ROOT;
        if (ra_ctx.still) begin
            n_stat = ST_STILL;
        end else if (ra_ctx.lin) begin
            if (ra_ctx.absdot == '0) begin
                n_stat = ST_LINEAR;
            end else if (ra_ctx.dot_neg) begin
                n_do  = 1'b1;
                n_num = NUM_W'(ra_ctx.c) << (OUT_FRAC - 1);
                n_den = ra_ctx.absdot;
            end
        end else if (ra_ctx.dneg) begin
            n_stat = ST_NOROOT;
        end else if (w_ok0 || w_ok1) begin
            n_do  = 1'b1;
            n_num = NUM_W'(w_best) << OUT_FRAC;
            n_den = ra_ctx.absa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vo <= r_dv[TIME_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_ctx <= i_ctx;
            ra_n0  <= w_mdot + w_rt;
            ra_n1  <= w_mdot - w_rt;

            rb_do   <= n_do;
            rb_num  <= n_num;
            rb_den  <= n_den;
            rb_stat <= n_stat;

            rc_do   <= rb_do;
            rc_sat  <= rb_do && (CMP_W'(rb_num) >= {rb_den, TIME_W'(0)});
            rc_rem  <= CMP_W'(rb_num);
            rc_den  <= rb_den;
            rc_stat <= rb_stat;

            r_out.hit_time     <= r_dsat[TIME_W-1] ? '1
                                  : (r_ddo[TIME_W-1] ? r_dq[TIME_W-1] : '0);
            r_out.solve_status <= r_dsat[TIME_W-1] ? ST_SAT : r_dst[TIME_W-1];
        end
    end

    for (genvar k = 0; k < TIME_W; k++) begin : g_bit
        localparam int BIT = TIME_W - 1 - k;
        logic                w_v, w_do, w_sat;
        logic [STAT_W-1:0]   w_st;
        logic [SUM_W-1:0]    w_den;
        logic [CMP_W-1:0]    w_rem, w_sh;
        logic [TIME_W-1:0]   w_q;

        if (k == 0) begin : g_first
            assign w_v   = r_vc;
            assign w_do  = rc_do;
            assign w_sat = rc_sat;
            assign w_st  = rc_stat;
            assign w_den = rc_den;
            assign w_rem = rc_rem;
            assign w_q   = '0;
        end else begin : g_next
            assign w_v   = r_dv[k-1];
            assign w_do  = r_ddo[k-1];
            assign w_sat = r_dsat[k-1];
            assign w_st  = r_dst[k-1];
            assign w_den = r_dden[k-1];
            assign w_rem = r_drem[k-1];
            assign w_q   = r_dq[k-1];
        end

        assign w_sh = CMP_W'(w_den) << BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else if (i_en) begin
                r_dv[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ddo[k]  <= w_do;
                r_dsat[k] <= w_sat;
                r_dst[k]  <= w_st;
                r_dden[k] <= w_den;
                if (w_rem >= w_sh) begin
                    r_drem[k] <= w_rem - w_sh;
                    r_dq[k]   <= w_q | (TIME_W'(1) << BIT);
                end else begin
                    r_drem[k] <= w_rem;
                    r_dq[k]   <= w_q;
                end
            end
        end
    end

    assign o_valid = r_vo;
    assign o_data  = r_out;

endmodule

// ===== hdl/intercept_time_solver_core.sv =====
// Top level of the intercept time solver: a fully pipelined quadratic intercept solve.
//
// Input channel i_in_valid / o_in_ready carries one query per transfer: projectile speed
// and the target's relative position and velocity. Output channel o_out_valid /
// i_out_ready returns one result per query, in order: hit time in Q16.16 and a status.
// The near-zero limit is written through i_cfg_we / i_cfg_wdata; the user writes it only
// while the block is idle; the block does not enforce this. The pipeline has seven stages
// of products and sums, one stage per bit of the square root, three stages of root
// selection and range check, one stage per quotient bit of the divider and the result
// register. Throughput is one transfer per cycle while the receiver does not stall, set
// by the pipeline taking one query per stage. When the receiver stalls with a result
// waiting, the whole pipeline holds and the input is not ready; no item is lost or
// repeated. A synchronous reset empties all stages and sets the near-zero limit to one.
module intercept_time_solver_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  its_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output its_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [its_pkg::LIMIT_W-1:0]   i_cfg_wdata
);
    import its_pkg::*;

    logic                 r_limit_valid;
    logic [LIMIT_W-1:0]   r_limit;
    logic                 w_en;
    logic                 w_coef_v, w_disc_v, w_sqrt_v;
    t_ctx                 w_coef_ctx, w_disc_ctx, w_sqrt_ctx;
    logic [DISC_W-1:0]    w_dmag;
    logic [ROOT_W-1:0]    w_root;

    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit       <= LIMIT_W'(1);
            r_limit_valid <= 1'b1;
        end else if (i_cfg_we) begin
            r_limit       <= i_cfg_wdata;
            r_limit_valid <= 1'b1;
        end
    end

    its_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid && r_limit_valid),
        .i_data  (i_in_data),
        .i_limit (r_limit),
        .o_valid (w_coef_v),
        .o_ctx   (w_coef_ctx)
    );

    its_disc u_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_coef_v),
        .i_ctx   (w_coef_ctx),
        .o_valid (w_disc_v),
        .o_ctx   (w_disc_ctx),
        .o_dmag  (w_dmag)
    );

    its_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_disc_v),
        .i_ctx   (w_disc_ctx),
        .i_dmag  (w_dmag),
        .o_valid (w_sqrt_v),
        .o_ctx   (w_sqrt_ctx),
        .o_root  (w_root)
    );

    its_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sqrt_v),
        .i_ctx   (w_sqrt_ctx),
        .i_root  (w_root),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

    a_sat_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.solve_status == ST_SAT)
        |-> (o_out_data.hit_time == '1))
        else $error("Saturated result without an all-ones time.");

    a_zero_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_data.solve_status == ST_STILL)
                        || (o_out_data.solve_status == ST_NOROOT)
                        || (o_out_data.solve_status == ST_LINEAR))
        |-> (o_out_data.hit_time == '0))
        else $error("Special-case result carries a non-zero time.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result valid straight after reset.");

endmodule

// ===== sim/tb_intercept_time_solver_core.sv =====
// Self-checking testbench of the intercept time solver: directed and random queries, checked by table or predictor.
`timescale 1ns / 100ps

module tb_intercept_time_solver_core;
    import its_pkg::*;

    typedef struct {
        t_in_item  query;
        bit        typed;
        t_out_item answer;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_in_item            i_in_data;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out_data;
    logic                i_cfg_we;
    logic [LIMIT_W-1:0]  i_cfg_wdata;

    t_out_item           pending_answers[$];
    t_row                rows[$];
    logic [LIMIT_W-1:0]  limit_now;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  phase_now = -1;
    int                  hold_off_left = 0;
    bit                  hold_started = 1'b0;
    int                  quiet_cycles = 0;
    bit                  failed = 1'b0;

    intercept_time_solver_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [127:0] isqrt128(logic [127:0] x);
        logic [127:0] res;
        logic [127:0] cand;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = res | (128'd1 << b);
            if (cand * cand <= x) res = cand;
        end
        return res;
    endfunction

    function automatic t_out_item quotient_time(logic [127:0] num, logic [127:0] den);
        t_out_item r;
        if (num >= (den << 32)) begin
            r.hit_time = '1;
            r.solve_status = ST_SAT;
        end else begin
            r.hit_time = TIME_W'(num / den);
            r.solve_status = ST_ROOT;
        end
        return r;
    endfunction

    function automatic t_out_item solve_intercept(t_in_item q, logic [LIMIT_W-1:0] lim);
        t_out_item r;
        logic signed [127:0] px, py, pz, vx, vy, vz, spd;
        logic signed [127:0] velsq, c, dot, a, absa, d, rt, n0, n1, best;
        bit have;
        px = q.pos_x; py = q.pos_y; pz = q.pos_z;
        vx = q.vel_x; vy = q.vel_y; vz = q.vel_z;
        spd = $signed({105'd0, q.proj_speed});
        velsq = vx * vx + vy * vy + vz * vz;
        c = px * px + py * py + pz * pz;
        dot = vx * px + vy * py + vz * pz;
        r.hit_time = '0;
        r.solve_status = ST_ROOT;
        if (velsq < lim) begin
            r.solve_status = ST_STILL;
            return r;
        end
        a = velsq - spd * spd;
        absa = (a < 0) ? -a : a;
        if (a == 0 || absa < lim) begin
            if (dot == 0) r.solve_status = ST_LINEAR;
            else if (dot < 0) r = quotient_time(c << (OUT_FRAC - 1), -dot);
            return r;
        end
        d = dot * dot - a * c;
        if (d < 0) begin
            r.solve_status = ST_NOROOT;
            return r;
        end
        rt = isqrt128(d);
        n0 = -dot + rt;
        n1 = -dot - rt;
        have = 0;
        best = 0;
        if (n0 != 0 && ((n0 < 0) == (a < 0))) begin
            best = (n0 < 0) ? -n0 : n0;
            have = 1;
        end
        if (n1 != 0 && ((n1 < 0) == (a < 0))) begin
            if (!have || ((n1 < 0) ? -n1 : n1) < best) best = (n1 < 0) ? -n1 : n1;
            have = 1;
        end
        if (have) r = quotient_time(best << OUT_FRAC, absa);
        return r;
    endfunction

    function automatic logic signed [IN_WIDTH-1:0] rand_axis(int bits);
        logic [IN_WIDTH-1:0] raw;
        raw = IN_WIDTH'($urandom & ((32'd1 << bits) - 1));
        return $signed(raw) - $signed(IN_WIDTH'(1) << (bits - 1));
    endfunction

    function automatic t_in_item random_query();
        t_in_item q;
        logic [191:0] raw_bits;
        int sel;
        int kp;
        int kv;
        sel = $urandom_range(0, 9);
        kp = $urandom_range(4, IN_WIDTH);
        kv = $urandom_range(2, IN_WIDTH - 2);
        if (sel == 0) begin
            raw_bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            q = raw_bits[$bits(t_in_item)-1:0];
        end else if (sel == 1) begin
            q.proj_speed = (IN_WIDTH-1)'($urandom_range(0, (1 << kv) - 1));
            q.vel_x = ($urandom_range(0, 1) != 0) ? -$signed({1'b0, q.proj_speed})
                                                  : $signed({1'b0, q.proj_speed});
            q.vel_y = '0;
            q.vel_z = '0;
            q.pos_x = rand_axis(kp);
            q.pos_y = rand_axis(kp);
            q.pos_z = rand_axis(kp);
        end else begin
            q.pos_x = rand_axis(kp);
            q.pos_y = rand_axis(kp);
            q.pos_z = rand_axis(kp);
            q.vel_x = rand_axis(kv);
            q.vel_y = rand_axis(kv);
            q.vel_z = rand_axis(kv);
            q.proj_speed = (IN_WIDTH-1)'($urandom
                                          & ((32'd1 << (kv + $urandom_range(0, 1))) - 1));
            if (sel == 2) q.pos_x = ($urandom_range(0, 1) != 0) ? 24'sh800000 : 24'sh7FFFFF;
        end
        return q;
    endfunction

    task automatic add_row(logic [IN_WIDTH-2:0] s, int px, int py, int pz,
                           int vx, int vy, int vz, bit typed,
                           logic [TIME_W-1:0] t, logic [STAT_W-1:0] st);
        t_row r;
        r.query = '{s, IN_WIDTH'(px), IN_WIDTH'(py), IN_WIDTH'(pz),
                    IN_WIDTH'(vx), IN_WIDTH'(vy), IN_WIDTH'(vz)};
        r.typed = typed;
        r.answer = '{t, st};
        rows = {rows, r};
    endtask

    task automatic send_query(t_in_item q, bit typed, t_out_item typed_answer);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= q;
        do @(posedge i_clk); while (!o_in_ready);
        pending_answers = {pending_answers,
                           (typed ? typed_answer : solve_intercept(q, limit_now))};
    endtask

    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        limit_now = value;
    endtask

    always @(posedge i_clk) begin
        if (phase_now == 4 && !hold_started) begin
            hold_started <= 1'b1;
            hold_off_left <= 400;
            i_out_ready <= 1'b0;
        end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: result with none expected: time %h status %0d", $time,
                         o_out_data.hit_time, o_out_data.solve_status);
                failed = 1;
            end else begin
                t_out_item e;
                e = pending_answers.pop_front();
                if (o_out_data.hit_time !== e.hit_time) begin
                    $display("%0t: hit_time expected %h actual %h", $time, e.hit_time,
                             o_out_data.hit_time);
                    failed = 1;
                end
                if (o_out_data.solve_status !== e.solve_status) begin
                    $display("%0t: solve_status expected %0d actual %0d", $time,
                             e.solve_status, o_out_data.solve_status);
                    failed = 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 20000) begin
            $display("FAIL intercept_time_solver_core");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [LIMIT_W-1:0] limits [8];
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        limit_now = 1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(0, 0, 0, 0, 0, 0, 0, 1, 0, ST_STILL);
        add_row(23'h7FFFFF, 8388607, 8388607, 8388607, 0, 0, 0, 1, 0, ST_STILL);
        add_row(4096, 0, 4096, 0, 4096, 0, 0, 1, 0, ST_LINEAR);
        add_row(4096, -4096, 0, 0, 4096, 0, 0, 0, 0, ST_ROOT);
        add_row(4096, 4096, 0, 0, 4096, 0, 0, 1, 0, ST_ROOT);
        add_row(4096, 1, 8388607, 0, -4096, 0, 0, 1, 32'hFFFFFFFF, ST_SAT);
        add_row(0, 0, 4096, 0, 4096, 0, 0, 1, 0, ST_NOROOT);
        add_row(0, -4096, 0, 0, 4096, 0, 0, 0, 0, ST_ROOT);
        add_row(0, 4096, 0, 0, 4096, 0, 0, 1, 0, ST_ROOT);
        add_row(8192, 40960, 0, 0, 4096, 0, 0, 0, 0, ST_ROOT);
        add_row(8192, -40960, 12000, -300, 4096, -2048, 100, 0, 0, ST_ROOT);
        add_row(0, 100, 0, 0, 1, 0, 0, 0, 0, ST_ROOT);
        add_row(23'h7FFFFF, -8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
                0, 0, ST_ROOT);
        add_row(23'h7FFFFF, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                0, 0, ST_ROOT);
        add_row(0, 8388607, -8388608, 5, -8388608, 8388607, -1, 0, 0, ST_ROOT);
        add_row(23'h7FFFFF, 8388607, 0, 0, -1, 0, 0, 0, 0, ST_ROOT);
        foreach (rows[i]) send_query(rows[i].query, rows[i].typed, rows[i].answer);
        drain_and_settle();

        limits = '{16'd0, 16'd65535, 16'd1, 16'd300, 16'd65535, 16'd0, 16'd1, 16'd4096};
        for (int ph = 0; ph < 8; ph++) begin
            write_limit((ph == 7) ? LIMIT_W'($urandom) : limits[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            phase_now = ph;
            for (int k = 0; k < 86; k++) begin
                if (ph == 5 && k == 43) begin
                    i_in_valid <= 1'b0;
                    while (pending_answers.size() != 0) @(posedge i_clk);
                end
                send_query(random_query(), 0, '0);
            end
            drain_and_settle();
        end

        if (!failed)
            $display("PASS intercept_time_solver_core");
        else
            $display("FAIL intercept_time_solver_core");
        $finish;
    end

endmodule
